>>> hdl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants for the source text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    typedef enum logic [3:0] {
        KIND_IDENT    = 4'd0,
        KIND_NUMERIC  = 4'd1,
        KIND_TEXT     = 4'd2,
        KIND_FUNCTION = 4'd3,
        KIND_RETURN   = 4'd4,
        KIND_NUMBER   = 4'd5,
        KIND_ASSIGN   = 4'd6,
        KIND_LPAREN   = 4'd7,
        KIND_RPAREN   = 4'd8,
        KIND_END      = 4'd9,
        KIND_UNKNOWN  = 4'd10
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        logic [23:0] start;
        logic [7:0]  len;
        logic [23:0] line;
        logic [7:0]  sc;
        logic        too_long;
    } t_token;

    // one front transfer: one or two tokens
    typedef struct packed {
        logic   two;
        t_token tok0;
        t_token tok1;
    } t_rec;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ASSIGN = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    localparam int NUM_KW = 4;

    localparam int KW_LEN [NUM_KW] = '{7, 4, 8, 6};

    localparam t_kind KW_KIND [NUM_KW] = '{KIND_NUMERIC, KIND_TEXT, KIND_FUNCTION, KIND_RETURN};

    localparam logic [7:0] KW_CHARS [NUM_KW][8] = '{
        '{"n", "u", "m", "e", "r", "i", "c", 8'h00},
        '{"t", "e", "x", "t", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "u", "n", "c", "t", "i", "o", "n"},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
    };

endpackage

`default_nettype wire

>>> hdl/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// Scanner: classifies each source byte, tracks the open token and emits
// records of one or two finished tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_front import stt_pkg::*; #(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int OFFSET_BITS   = 24,
    parameter int LINE_BITS     = 24
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_acc,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_at_end,
    output t_rec            o_rec,
    output logic            o_push
);

    localparam int LEN_BITS = $clog2(MAX_TOKEN_LEN + 1);

    t_mode                  r_mode,  n_mode;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [LEN_BITS-1:0]    r_len,   n_len;
    logic [LINE_BITS-1:0]   r_tline, n_tline;
    logic [OFFSET_BITS-1:0] r_pos,   n_pos;
    logic [LINE_BITS-1:0]   r_line,  n_line;
    logic [NUM_KW-1:0]      r_alive, n_alive;
    logic                   r_ovf,   n_ovf;

    logic                   w_end, w_letter, w_digit, w_ident_ch, w_space, w_cont;
    logic [LEN_BITS-1:0]    g_len_in, g_len_out;
    logic [NUM_KW-1:0]      g_alive_in, g_alive_out;
    logic                   g_ovf;
    logic [OFFSET_BITS-1:0] w_pos_inc;
    logic [LINE_BITS-1:0]   w_line_inc;
    logic [OFFSET_BITS+23:0] w_pos_ext, w_start_ext;
    logic [LINE_BITS+23:0]  w_line_ext, w_tline_ext;
    logic [LEN_BITS+7:0]    w_len_ext;
    t_token                 w_close, w_new;
    logic                   w_have_close, w_have_new;

    assign w_end      = i_at_end || (i_ch == CH_NUL);
    assign w_letter   = (i_ch inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    assign w_digit    = (i_ch inside {[8'h30:8'h39]});
    assign w_ident_ch = w_letter || (i_ch == CH_UNDER);
    assign w_space    = (i_ch inside {CH_SPACE, CH_TAB, CH_NL});

    always_comb begin
        case (r_mode)
            MODE_IDENT:  w_cont = !w_end && (w_ident_ch || w_digit);
            MODE_NUMBER: w_cont = !w_end && (w_digit || i_ch == CH_DOT);
            default:     w_cont = 1'b0;
        endcase
    end

    // keyword prefix tracking and length count
    assign g_len_in   = w_cont ? r_len : '0;
    assign g_alive_in = w_cont ? r_alive : (w_ident_ch ? {NUM_KW{1'b1}} : '0);

    always_comb begin
        g_alive_out = g_alive_in;
        g_len_out   = g_len_in;
        g_ovf       = 1'b0;
        if (g_len_in >= LEN_BITS'(MAX_TOKEN_LEN)) begin
            g_ovf       = 1'b1;
            g_alive_out = '0;
        end else begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (!(g_len_in < LEN_BITS'(KW_LEN[k]) &&
                      KW_CHARS[k][g_len_in[2:0]] == i_ch)) begin
                    g_alive_out[k] = 1'b0;
                end
            end
            g_len_out = g_len_in + LEN_BITS'(1);
        end
    end

    assign w_pos_inc   = (&r_pos)  ? r_pos  : r_pos + OFFSET_BITS'(1);
    assign w_line_inc  = (&r_line) ? r_line : r_line + LINE_BITS'(1);
    assign w_pos_ext   = {24'd0, r_pos};
    assign w_start_ext = {24'd0, r_start};
    assign w_line_ext  = {24'd0, r_line};
    assign w_tline_ext = {24'd0, r_tline};
    assign w_len_ext   = {8'd0, r_len};

    // token being closed by this byte
    always_comb begin
        w_close          = '0;
        w_close.kind     = (r_mode == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
        w_close.start    = w_start_ext[23:0];
        w_close.len      = (w_len_ext > (LEN_BITS + 8)'(255)) ? 8'hFF : w_len_ext[7:0];
        w_close.line     = w_tline_ext[23:0];
        w_close.too_long = r_ovf;
        if (r_mode == MODE_IDENT) begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (r_alive[k] && !r_ovf && r_len == LEN_BITS'(KW_LEN[k])) begin
                    w_close.kind = KW_KIND[k];
                end
            end
        end
    end

    assign w_have_close = (r_mode == MODE_IDENT || r_mode == MODE_NUMBER) && !w_cont;

    always_comb begin
        n_mode     = r_mode;
        n_start    = r_start;
        n_len      = r_len;
        n_tline    = r_tline;
        n_pos      = r_pos;
        n_line     = r_line;
        n_alive    = r_alive;
        n_ovf      = r_ovf;
        w_new      = '0;
        w_new.line = w_line_ext[23:0];
        w_new.start = w_pos_ext[23:0];
        w_have_new = 1'b0;
        if (i_acc) begin
            if (w_cont) begin
                n_len   = g_len_out;
                n_alive = g_alive_out;
                n_ovf   = r_ovf || g_ovf;
                n_pos   = w_pos_inc;
            end else begin
                n_mode  = MODE_IDLE;
                n_alive = '0;
                if (w_end) begin
                    w_new.kind = KIND_END;
                    w_have_new = 1'b1;
                    n_pos      = '0;
                    n_line     = LINE_BITS'(1);
                end else begin
                    if (w_space) begin
                        if (i_ch == CH_NL) begin
                            n_line = w_line_inc;
                        end
                    end else if (w_ident_ch || w_digit) begin
                        n_mode  = w_ident_ch ? MODE_IDENT : MODE_NUMBER;
                        n_start = r_pos;
                        n_tline = r_line;
                        n_len   = g_len_out;
                        n_alive = g_alive_out;
                        n_ovf   = g_ovf;
                    end else begin
                        case (i_ch)
                            CH_ASSIGN: w_new.kind = KIND_ASSIGN;
                            CH_LPAREN: w_new.kind = KIND_LPAREN;
                            CH_RPAREN: w_new.kind = KIND_RPAREN;
                            default:   w_new.kind = KIND_UNKNOWN;
                        endcase
                        w_new.len  = 8'd1;
                        w_new.sc   = i_ch;
                        w_have_new = 1'b1;
                    end
                    n_pos = w_pos_inc;
                end
            end
        end
    end

    assign o_push    = i_acc && (w_have_close || w_have_new);
    assign o_rec.two  = w_have_close && w_have_new;
    assign o_rec.tok0 = w_have_close ? w_close : w_new;
    assign o_rec.tok1 = w_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_len   <= '0;
            r_tline <= LINE_BITS'(1);
            r_pos   <= '0;
            r_line  <= LINE_BITS'(1);
            r_alive <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_len   <= n_len;
            r_tline <= n_tline;
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_alive <= n_alive;
            r_ovf   <= n_ovf;
        end
    end

endmodule

`default_nettype wire

>>> hdl/stt_fifo.sv
// ----------------------------------------------------------------------------
// stt_fifo
// Short queue of token records between scanner and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_fifo import stt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_rec i_rec,
    input  wire logic i_pop,
    output t_rec      o_head,
    output t_q_stat   o_stat
);

    t_rec                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [FIFO_AW:0]     r_cnt;
    logic                 w_push, w_pop;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + FIFO_AW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + (FIFO_AW + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (FIFO_AW + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back
// Output stage: splits each record into tokens, one per cycle while not
// stalled by i_m_tready, into a registered stream output.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_back import stt_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_rec        i_head,
    input  wire t_q_stat     i_stat,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [71:0]      o_m_tdata,
    output logic [3:0]       o_m_tuser,
    output logic             o_m_tlast
);

    logic   r_valid;
    logic   r_half, n_half;
    t_token r_tok, n_tok;
    logic   r_last, n_last;
    logic   w_load;

    assign w_load = !r_valid || i_m_tready;

    always_comb begin
        n_half = r_half;
        n_tok  = r_tok;
        n_last = r_last;
        o_pop  = 1'b0;
        if (w_load && !i_stat.empty) begin
            if (i_head.two && !r_half) begin
                n_tok  = i_head.tok0;
                n_last = 1'b0;
                n_half = 1'b1;
            end else begin
                n_tok  = i_head.two ? i_head.tok1 : i_head.tok0;
                n_last = 1'b1;
                n_half = 1'b0;
                o_pop  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            r_half <= n_half;
            if (w_load) begin
                r_valid <= !i_stat.empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok  <= n_tok;
        r_last <= n_last;
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_tok.kind;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = {7'd0, r_tok.too_long, r_tok.sc, r_tok.line, r_tok.len, r_tok.start};

endmodule

`default_nettype wire

>>> hdl/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: source bytes in, tokens with offset, length and line out.
//
//  port group      dir  tdata                          tuser        tlast
//  i_s_*/o_s_*     in   [7:0] ch                       -            at_end
//  o_m_*           out  start/len/line/char/too_long   token_kind   last token
//
// One byte accepted per cycle while the queue is not full; the scanner state
// updates in that cycle. Tokens leave the output register one per cycle while
// i_m_tready is high; a byte that closes a token and makes another yields two.
// A four-record queue decouples scanner and output; o_s_tready drops only
// when the queue is full. Synchronous reset clears scanner and queue.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer import stt_pkg::*; #(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int OFFSET_BITS   = 24,
    parameter int LINE_BITS     = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] ch
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [23:0] start_offset, [31:24] token_length, [55:32] line_number,
    // [63:56] single_char, [64] too_long, [71:65] zero
    output logic [71:0]      o_m_tdata,
    output logic [3:0]       o_m_tuser,   // [3:0] token_kind
    output logic             o_m_tlast
);

    t_rec    w_rec, w_head;
    logic    w_push, w_pop, w_acc;
    t_q_stat w_stat;

    assign o_s_tready = !w_stat.full;
    assign w_acc      = i_s_tvalid && o_s_tready;

    stt_front #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .OFFSET_BITS   (OFFSET_BITS),
        .LINE_BITS     (LINE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (w_acc),
        .i_ch     (i_s_tdata),
        .i_at_end (i_s_tlast),
        .o_rec    (w_rec),
        .o_push   (w_push)
    );

    stt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    stt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_stat     (w_stat),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

>>> hdl/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks on the token stream, bound to the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_checker import stt_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [71:0] o_m_tdata,
    input wire logic [3:0]  o_m_tuser,
    input wire logic        o_m_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output changed while stalled");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_END |-> o_m_tlast && o_m_tdata[31:24] == 8'd0
            && o_m_tdata[64] == 1'b0)
        else $error("bad end token");

    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tuser <= KIND_NUMBER)
        else $error("leading token of a pair is not a closed word or number");

    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser <= KIND_NUMBER || o_m_tuser == KIND_END)
            |-> o_m_tdata[63:56] == 8'd0)
        else $error("char field set on a multi-byte token");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_ASSIGN || o_m_tuser == KIND_LPAREN
            || o_m_tuser == KIND_RPAREN || o_m_tuser == KIND_UNKNOWN)
            |-> o_m_tdata[31:24] == 8'd1 && o_m_tlast)
        else $error("bad single byte token");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);

`default_nettype wire
